>>> src/rqp_pkg.sv
`timescale 1ns / 1ps

package rqp_pkg;

  localparam int unsigned ChrW   = 21;
  localparam int unsigned CountW = 30;

  // A count that has reached this value takes no further digit.
  localparam logic [CountW-1:0] BIG_LIMIT = CountW'(100000000);

  localparam logic [ChrW-1:0] CH_STAR   = ChrW'(8'h2A);
  localparam logic [ChrW-1:0] CH_PLUS   = ChrW'(8'h2B);
  localparam logic [ChrW-1:0] CH_QUEST  = ChrW'(8'h3F);
  localparam logic [ChrW-1:0] CH_LBRACE = ChrW'(8'h7B);
  localparam logic [ChrW-1:0] CH_RBRACE = ChrW'(8'h7D);
  localparam logic [ChrW-1:0] CH_COMMA  = ChrW'(8'h2C);
  localparam logic [ChrW-1:0] CH_ZERO   = ChrW'(8'h30);
  localparam logic [ChrW-1:0] CH_NINE   = ChrW'(8'h39);

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_BRACE  = 6'b000010,
    PH_LOW    = 6'b000100,
    PH_COMMA  = 6'b001000,
    PH_HIGH   = 6'b010000,
    PH_SUFFIX = 6'b100000
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NOTQ    = 3'd1,
    ST_BIG     = 3'd2,
    ST_ORDER   = 3'd3,
    ST_NOTHING = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    MODE_GREEDY     = 2'd0,
    MODE_LAZY       = 2'd1,
    MODE_POSSESSIVE = 2'd2
  } mode_e;

  typedef struct packed {
    logic [ChrW-1:0] chr;
    logic            end_of_pattern;
    logic            has_operand;
  } in_t;

  typedef struct packed {
    logic              consumed;
    logic              done_res;
    status_e           status;
    logic [CountW-1:0] min_count;
    logic [CountW-1:0] max_count;
    logic              max_unbounded;
    mode_e             repeat_mode;
    logic              unit_repeat;
  } out_t;

  typedef struct packed {
    phase_e            phase;
    logic [CountW-1:0] accumulator;
    logic [CountW-1:0] lower_bound;
    logic              upper_unbounded;
    logic              operand_ok;
  } state_t;

endpackage

>>> src/rqp_step.sv
`timescale 1ns / 1ps

module rqp_step import rqp_pkg::*; (
  input  state_t st_i,
  input  in_t    beat_i,
  output state_t st_o,
  output out_t   res_o
);

  logic              is_digit;
  logic              is_comma;
  logic              is_rbrace;
  logic [CountW-1:0] dig_val;
  logic [CountW-1:0] acc_next;
  logic              acc_big;

  assign is_digit  = !beat_i.end_of_pattern && (beat_i.chr >= CH_ZERO) &&
                     (beat_i.chr <= CH_NINE);
  assign is_comma  = !beat_i.end_of_pattern && (beat_i.chr == CH_COMMA);
  assign is_rbrace = !beat_i.end_of_pattern && (beat_i.chr == CH_RBRACE);
  assign dig_val   = CountW'(beat_i.chr[3:0]);
  assign acc_big   = st_i.accumulator >= BIG_LIMIT;
  // Times ten as two shifted copies; the value stays below 2^30 when not too big.
  assign acc_next  = (st_i.accumulator << 3) + (st_i.accumulator << 1) + dig_val;

  always_comb begin
    st_o  = st_i;
    res_o = '0;
    res_o.status      = ST_OK;
    res_o.repeat_mode = MODE_GREEDY;
    unique case (st_i.phase) inside
      PH_BRACE: begin
        if (!is_digit) begin
          st_o.phase     = PH_IDLE;
          res_o.done_res = 1'b1;
          res_o.status   = ST_NOTQ;
        end else begin
          st_o.accumulator = dig_val;
          st_o.phase       = PH_LOW;
          res_o.consumed   = 1'b1;
        end
      end
      PH_LOW, PH_HIGH: begin
        if (is_digit) begin
          if (acc_big) begin
            st_o.phase     = PH_IDLE;
            res_o.done_res = 1'b1;
            res_o.status   = ST_BIG;
          end else begin
            st_o.accumulator = acc_next;
            res_o.consumed   = 1'b1;
          end
        end else if (is_comma && st_i.phase == PH_LOW) begin
          st_o.lower_bound     = st_i.accumulator;
          st_o.accumulator     = '0;
          st_o.upper_unbounded = 1'b1;
          st_o.phase           = PH_COMMA;
          res_o.consumed       = 1'b1;
        end else if (is_rbrace) begin
          res_o.consumed = 1'b1;
          if (st_i.phase == PH_LOW) begin
            st_o.lower_bound     = st_i.accumulator;
            st_o.upper_unbounded = 1'b0;
          end
          // In the upper digits the bound is finite, so order is checked here.
          if (st_i.phase == PH_HIGH && !st_i.upper_unbounded &&
              st_i.accumulator < st_i.lower_bound) begin
            st_o.phase     = PH_IDLE;
            res_o.done_res = 1'b1;
            res_o.status   = ST_ORDER;
          end else if (!st_i.operand_ok) begin
            st_o.phase     = PH_IDLE;
            res_o.done_res = 1'b1;
            res_o.status   = ST_NOTHING;
          end else begin
            st_o.phase = PH_SUFFIX;
          end
        end else begin
          st_o.phase     = PH_IDLE;
          res_o.done_res = 1'b1;
          res_o.status   = ST_NOTQ;
        end
      end
      PH_COMMA: begin
        if (is_digit) begin
          st_o.accumulator     = dig_val;
          st_o.upper_unbounded = 1'b0;
          st_o.phase           = PH_HIGH;
          res_o.consumed       = 1'b1;
        end else if (is_rbrace) begin
          st_o.accumulator     = '0;
          st_o.upper_unbounded = 1'b1;
          res_o.consumed       = 1'b1;
          if (!st_i.operand_ok) begin
            st_o.phase     = PH_IDLE;
            res_o.done_res = 1'b1;
            res_o.status   = ST_NOTHING;
          end else begin
            st_o.phase = PH_SUFFIX;
          end
        end else begin
          st_o.phase     = PH_IDLE;
          res_o.done_res = 1'b1;
          res_o.status   = ST_NOTQ;
        end
      end
      PH_SUFFIX: begin
        st_o.phase           = PH_IDLE;
        res_o.done_res       = 1'b1;
        res_o.min_count      = st_i.lower_bound;
        res_o.max_count      = st_i.upper_unbounded ? '0 : st_i.accumulator;
        res_o.max_unbounded  = st_i.upper_unbounded;
        if (!beat_i.end_of_pattern && beat_i.chr == CH_QUEST) begin
          res_o.consumed    = 1'b1;
          res_o.repeat_mode = MODE_LAZY;
        end else if (!beat_i.end_of_pattern && beat_i.chr == CH_PLUS) begin
          res_o.consumed    = 1'b1;
          res_o.repeat_mode = MODE_POSSESSIVE;
        end
        // Equal bounds leave nothing for laziness or possessiveness to change.
        if (!st_i.upper_unbounded && st_i.accumulator == st_i.lower_bound) begin
          res_o.repeat_mode = MODE_GREEDY;
        end
        res_o.unit_repeat = !st_i.upper_unbounded &&
                            st_i.lower_bound == CountW'(1) &&
                            st_i.accumulator == CountW'(1);
      end
      default: begin
        st_o.phase = PH_IDLE;
        if (beat_i.end_of_pattern) begin
          res_o.done_res = 1'b1;
          res_o.status   = ST_NOTQ;
        end else begin
          st_o.operand_ok = beat_i.has_operand;
          if (beat_i.chr == CH_LBRACE) begin
            st_o.accumulator     = '0;
            st_o.lower_bound     = '0;
            st_o.upper_unbounded = 1'b0;
            st_o.phase           = PH_BRACE;
            res_o.consumed       = 1'b1;
          end else if (beat_i.chr == CH_STAR || beat_i.chr == CH_PLUS ||
                       beat_i.chr == CH_QUEST) begin
            st_o.lower_bound     = (beat_i.chr == CH_PLUS) ? CountW'(1) : '0;
            st_o.accumulator     = (beat_i.chr == CH_QUEST) ? CountW'(1) : '0;
            st_o.upper_unbounded = (beat_i.chr != CH_QUEST);
            res_o.consumed       = 1'b1;
            if (!beat_i.has_operand) begin
              res_o.done_res = 1'b1;
              res_o.status   = ST_NOTHING;
            end else begin
              st_o.phase = PH_SUFFIX;
            end
          end else begin
            res_o.done_res = 1'b1;
            res_o.status   = ST_NOTQ;
          end
        end
      end
    endcase
  end

endmodule

>>> src/regex_quantifier_parser.sv
`timescale 1ns / 1ps
// The result for a character is registered and appears in the cycle after its beat is accepted.
// Throughput: one character per cycle; the parse state and the result register
// are both updated in the cycle of acceptance, so input is held only while a
// result waits and the output side stalls.
// Reset (rst_ni low, asynchronous) returns the parser to idle with cleared counts.
module regex_quantifier_parser import rqp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  state_t state_q, state_d;
  out_t   res_q, res_d;
  logic   out_valid_q;
  logic   accept;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  rqp_step u_step (
    .st_i   (state_q),
    .beat_i (in_data_i),
    .st_o   (state_d),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '{phase: PH_IDLE, accumulator: '0, lower_bound: '0,
                       upper_unbounded: 1'b0, operand_ok: 1'b0};
      out_valid_q <= 1'b0;
    end else if (accept) begin
      state_q     <= state_d;
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import rqp_pkg::*;

  localparam logic [CountW-1:0] DECIMAL = CountW'(10);
  localparam int HOLD_CYCLES = 200;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;

  regex_quantifier_parser DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  class quantifier_check;
    phase_e            ph;
    logic [CountW-1:0] acc;
    logic [CountW-1:0] lo;
    logic              unb;
    logic              op_ok;
    out_t              pending_verdicts[$];
    int                mismatches;

    function new();
      ph = PH_IDLE;
      acc = '0;
      lo = '0;
      unb = 1'b0;
      op_ok = 1'b0;
      mismatches = 0;
    endfunction

    function int pending();
      return pending_verdicts.size();
    endfunction

    // The quantifier is decided with an error or a literal brace.
    function out_t conclude(logic cons, status_e st);
      out_t r;
      r = '0;
      ph = PH_IDLE;
      r.consumed = cons;
      r.done_res = 1'b1;
      r.status = st;
      return r;
    endfunction

    // Bounds are complete: order wins over a missing operand.
    function out_t close_bounds();
      out_t r;
      r = '0;
      if (!unb && acc < lo) begin
        r = conclude(1'b1, ST_ORDER);
      end else if (!op_ok) begin
        r = conclude(1'b1, ST_NOTHING);
      end else begin
        ph = PH_SUFFIX;
        r.consumed = 1'b1;
      end
      return r;
    endfunction

    function out_t parse_char(in_t c);
      out_t              r;
      logic              is_digit;
      logic              is_comma;
      logic              is_close;
      logic              is_rep;
      logic [CountW-1:0] dval;
      logic [CountW-1:0] upper;
      mode_e             m;
      r = '0;
      r.consumed = 1'b1;
      is_digit = !c.end_of_pattern && c.chr >= CH_ZERO && c.chr <= CH_NINE;
      is_comma = !c.end_of_pattern && c.chr == CH_COMMA;
      is_close = !c.end_of_pattern && c.chr == CH_RBRACE;
      dval = CountW'(c.chr - CH_ZERO);
      case (ph)
        PH_BRACE: begin
          if (is_digit) begin
            acc = dval;
            ph = PH_LOW;
          end else begin
            r = conclude(1'b0, ST_NOTQ);
          end
        end
        PH_LOW, PH_HIGH: begin
          if (is_digit) begin
            if (acc >= BIG_LIMIT) begin
              r = conclude(1'b0, ST_BIG);
            end else begin
              acc = acc * DECIMAL + dval;
            end
          end else if (is_comma && ph == PH_LOW) begin
            lo = acc;
            acc = '0;
            unb = 1'b1;
            ph = PH_COMMA;
          end else if (is_close) begin
            if (ph == PH_LOW) begin
              lo = acc;
              unb = 1'b0;
            end
            r = close_bounds();
          end else begin
            r = conclude(1'b0, ST_NOTQ);
          end
        end
        PH_COMMA: begin
          if (is_digit) begin
            acc = dval;
            unb = 1'b0;
            ph = PH_HIGH;
          end else if (is_close) begin
            acc = '0;
            unb = 1'b1;
            r = close_bounds();
          end else begin
            r = conclude(1'b0, ST_NOTQ);
          end
        end
        PH_SUFFIX: begin
          m = MODE_GREEDY;
          r.consumed = 1'b0;
          if (!c.end_of_pattern && c.chr == CH_QUEST) begin
            m = MODE_LAZY;
            r.consumed = 1'b1;
          end else if (!c.end_of_pattern && c.chr == CH_PLUS) begin
            m = MODE_POSSESSIVE;
            r.consumed = 1'b1;
          end
          upper = unb ? '0 : acc;
          // Equal bounds leave nothing to be lazy or possessive about.
          if (!unb && acc == lo) m = MODE_GREEDY;
          ph = PH_IDLE;
          r.done_res = 1'b1;
          r.status = ST_OK;
          r.min_count = lo;
          r.max_count = upper;
          r.max_unbounded = unb;
          r.repeat_mode = m;
          r.unit_repeat = !unb && lo == CountW'(1) && upper == CountW'(1);
        end
        default: begin
          if (c.end_of_pattern) begin
            r = conclude(1'b0, ST_NOTQ);
          end else begin
            op_ok = c.has_operand;
            if (c.chr == CH_LBRACE) begin
              acc = '0;
              lo = '0;
              unb = 1'b0;
              ph = PH_BRACE;
            end else begin
              is_rep = 1'b1;
              if (c.chr == CH_STAR) begin
                lo = '0;
                acc = '0;
                unb = 1'b1;
              end else if (c.chr == CH_PLUS) begin
                lo = CountW'(1);
                acc = '0;
                unb = 1'b1;
              end else if (c.chr == CH_QUEST) begin
                lo = '0;
                acc = CountW'(1);
                unb = 1'b0;
              end else begin
                is_rep = 1'b0;
              end
              if (!is_rep) begin
                r = conclude(1'b0, ST_NOTQ);
              end else if (!op_ok) begin
                r = conclude(1'b1, ST_NOTHING);
              end else begin
                ph = PH_SUFFIX;
              end
            end
          end
        end
      endcase
      return r;
    endfunction

    function void note_char(in_t c);
      pending_verdicts.push_back(parse_char(c));
    endfunction

    function string describe(out_t v);
      return $sformatf("cons=%0b done=%0b status=%0d min=%0d max=%0d unb=%0b mode=%0d unit=%0b",
                       v.consumed, v.done_res, v.status, v.min_count, v.max_count,
                       v.max_unbounded, v.repeat_mode, v.unit_repeat);
    endfunction

    function void check_verdict(out_t got);
      out_t want;
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: %s", describe(got));
      end else begin
        want = pending_verdicts.pop_front();
        if (got.consumed !== want.consumed || got.done_res !== want.done_res ||
            got.status !== want.status || got.min_count !== want.min_count ||
            got.max_count !== want.max_count || got.max_unbounded !== want.max_unbounded ||
            got.repeat_mode !== want.repeat_mode || got.unit_repeat !== want.unit_repeat) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch at %0t", $realtime);
            $display("  expected %s", describe(want));
            $display("  actual   %s", describe(got));
          end
        end
      end
    endfunction
  endclass

  quantifier_check qchk;
  in_t             char_stream[$];
  int              send_gap_pct;
  int              recv_stall_pct;
  bit              hold_request = 1'b0;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) qchk.check_verdict(out_data_o);
      if (in_valid_i && !in_stall_o) qchk.note_char(in_data_i);
    end
  end

  // Receiver: random stalls, or one long hold-off when asked for.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  function automatic logic [ChrW-1:0] noise_chr();
    case ($urandom_range(0, 11))
      0:       return CH_STAR;
      1:       return CH_PLUS;
      2:       return CH_QUEST;
      3:       return CH_LBRACE;
      4:       return CH_RBRACE;
      5:       return CH_COMMA;
      6:       return CH_ZERO + ChrW'($urandom_range(0, 9));
      7:       return CH_ZERO - ChrW'(1);
      8:       return CH_NINE + ChrW'(1);
      9:       return '1;
      default: return ChrW'($urandom_range(0, 2097151));
    endcase
  endfunction

  function automatic int unsigned pick_count();
    case ($urandom_range(0, 19))
      0:          return 999999999;
      1:          return $urandom_range(100000000, 999999999);
      2, 3:       return $urandom_range(0, 999999999);
      4, 5, 6, 7: return $urandom_range(10, 999);
      default:    return $urandom_range(0, 9);
    endcase
  endfunction

  task automatic push_char(logic [ChrW-1:0] c, logic eop, logic opnd);
    in_t item;
    item.chr = eop ? ChrW'($urandom_range(0, 2097151)) : c;
    item.end_of_pattern = eop;
    item.has_operand = opnd;
    char_stream.push_back(item);
  endtask

  task automatic push_count(int unsigned v);
    int unsigned t;
    int unsigned dq[$];
    t = v;
    do begin
      dq.push_front(t % 10);
      t = t / 10;
    end while (t != 0);
    if ($urandom_range(0, 24) == 0) repeat ($urandom_range(1, 3)) dq.push_front(0);
    // Now and then a count of ten or more digits, which must overflow.
    if ($urandom_range(0, 29) == 0) begin
      dq.delete();
      dq.push_back($urandom_range(1, 9));
      repeat ($urandom_range(9, 10)) dq.push_back($urandom_range(0, 9));
    end
    foreach (dq[i]) push_char(CH_ZERO + ChrW'(dq[i]), 1'b0, 1'($urandom_range(0, 1)));
  endtask

  task automatic queue_run();
    int          kind;
    int          form;
    int          cut;
    int unsigned n;
    int unsigned m;
    logic        op;
    kind = $urandom_range(0, 99);
    op = ($urandom_range(0, 7) != 0);
    if (kind < 12) begin
      push_char(noise_chr(), ($urandom_range(0, 5) == 0), op);
    end else begin
      // A broken brace form stops early and ends in some stray character.
      cut = (kind >= 90) ? $urandom_range(0, 3) : 4;
      if (kind < 35) begin
        case ($urandom_range(0, 2))
          0:       push_char(CH_STAR, 1'b0, op);
          1:       push_char(CH_PLUS, 1'b0, op);
          default: push_char(CH_QUEST, 1'b0, op);
        endcase
      end else begin
        n = pick_count();
        form = $urandom_range(0, 2);
        push_char(CH_LBRACE, 1'b0, op);
        if (cut > 0) push_count(n);
        if (cut > 1 && form != 0) push_char(CH_COMMA, 1'b0, 1'($urandom_range(0, 1)));
        if (cut > 2 && form == 2) begin
          case ($urandom_range(0, 9))
            0, 1:    m = (n > 0) ? $urandom_range(0, n - 1) : 0;
            2, 3:    m = n;
            default: m = n + $urandom_range(0, 20);
          endcase
          push_count(m);
        end
        if (cut > 3) begin
          push_char(CH_RBRACE, 1'b0, 1'($urandom_range(0, 1)));
        end else begin
          push_char(noise_chr(), ($urandom_range(0, 3) == 0), 1'($urandom_range(0, 1)));
        end
      end
      if (cut > 3) begin
        case ($urandom_range(0, 3))
          0:       push_char(CH_QUEST, 1'b0, 1'($urandom_range(0, 1)));
          1:       push_char(CH_PLUS, 1'b0, 1'($urandom_range(0, 1)));
          2:       push_char(noise_chr(), 1'b0, 1'($urandom_range(0, 1)));
          default: push_char('0, 1'b1, 1'($urandom_range(0, 1)));
        endcase
      end
    end
  endtask

  task automatic offer(in_t item);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_items(int count);
    in_t item;
    for (int i = 0; i < count; i++) begin
      if (char_stream.size() == 0) queue_run();
      item = char_stream.pop_front();
      offer(item);
    end
  endtask

  // The last accepted beat is noted at the same edge, so look from the next edge on.
  task automatic drain();
    @(posedge clk_i);
    while (qchk.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    qchk = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    send_gap_pct = 35;
    recv_stall_pct = 56;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed runs: each repeat mode, errors, a literal brace and the widest code point.
    push_char(CH_STAR, 1'b0, 1'b1);
    push_char('0, 1'b1, 1'b1);
    push_char(CH_PLUS, 1'b0, 1'b1);
    push_char(CH_QUEST, 1'b0, 1'b0);
    push_char(CH_QUEST, 1'b0, 1'b1);
    push_char(CH_PLUS, 1'b0, 1'b1);
    push_char(CH_QUEST, 1'b0, 1'b0);
    push_char('1, 1'b0, 1'b1);
    push_char('0, 1'b1, 1'b0);
    push_char(CH_LBRACE, 1'b0, 1'b1);
    push_char(CH_ZERO + ChrW'(1), 1'b0, 1'b0);
    push_char(CH_RBRACE, 1'b0, 1'b0);
    push_char(CH_PLUS, 1'b0, 1'b0);
    push_char(CH_LBRACE, 1'b0, 1'b0);
    push_char(CH_ZERO + ChrW'(3), 1'b0, 1'b1);
    push_char(CH_COMMA, 1'b0, 1'b1);
    push_char(CH_ZERO + ChrW'(1), 1'b0, 1'b1);
    push_char(CH_RBRACE, 1'b0, 1'b1);
    push_char(CH_LBRACE, 1'b0, 1'b1);
    push_char(CH_ZERO + ChrW'(2), 1'b0, 1'b0);
    push_char(CH_COMMA, 1'b0, 1'b0);
    push_char(CH_RBRACE, 1'b0, 1'b0);
    push_char(CH_QUEST, 1'b0, 1'b0);
    push_char(CH_LBRACE, 1'b0, 1'b1);
    push_char(CH_COMMA, 1'b0, 1'b1);
    send_items(char_stream.size());

    send_items(350);
    // The sender keeps offering while the receiver holds off, so the block backs up.
    hold_request = 1'b1;
    send_items(350);
    in_valid_i <= 1'b0;
    drain();

    send_gap_pct = 56;
    recv_stall_pct = 35;
    send_items(650);

    send_gap_pct = 0;
    recv_stall_pct = 0;
    send_items(650);
    in_valid_i <= 1'b0;
    drain();
    repeat (4) @(posedge clk_i);

    if (qchk.mismatches == 0 && qchk.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
